// ===== hw/rtl/oldr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oldr_pkg
// Shared types and codes for the ordered list deque with match-remove.
// ----------------------------------------------------------------------------
package oldr_pkg;

    // command codes
    localparam logic [1:0] CMD_FRONT  = 2'd0;
    localparam logic [1:0] CMD_BACK   = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] value;
    } t_item;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] element_count;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic front;
        logic alloc;
        logic link1;
        logic link2;
        logic step;
        logic unlink;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic       full;
        logic       cur_none;
        logic       step_limit;
        logic       match;
        logic [4:0] count;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== hw/rtl/oldr_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oldr_dpath
// Entry store with forward and backward links, head and tail pointers,
// element count and a stack of recycled slots.
// ----------------------------------------------------------------------------
module oldr_dpath #(
    parameter int CAPACITY = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire oldr_pkg::t_item  i_item,
    input  wire oldr_pkg::t_dp_cmd i_cmd,
    output oldr_pkg::t_dp_stat    o_stat
);
    import oldr_pkg::*;

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [IW-1:0] IDX_NONE = IW'(CAPACITY);

    logic signed [31:0] r_val_mem [CAPACITY];
    logic [IW-1:0]      r_fwd_mem [CAPACITY];
    logic [IW-1:0]      r_bwd_mem [CAPACITY];
    logic [AW-1:0]      r_stk_mem [CAPACITY];

    logic [IW-1:0]      r_head, r_tail, r_count, r_fill, r_sp, r_cur, r_steps;
    logic [AW-1:0]      r_slot;
    logic signed [31:0] r_value;
    logic signed [31:0] r_val_q;
    logic [IW-1:0]      r_fwd_q, r_bwd_q;
    logic [AW-1:0]      r_stk_q;

    logic               fwd_we, bwd_we, rd_en, fresh;
    logic [AW-1:0]      fwd_addr, bwd_addr, rd_addr, stk_rd;
    logic [IW-1:0]      fwd_data, bwd_data, slot_ext;

    assign slot_ext = IW'(r_slot);
    assign fresh    = (r_fill < IDX_NONE);
    assign rd_en    = i_cmd.load | i_cmd.step;
    assign rd_addr  = i_cmd.step ? r_fwd_q[AW-1:0] : r_head[AW-1:0];
    assign stk_rd   = AW'(r_sp - 1'b1);

    always_comb begin
        fwd_we   = 1'b0;
        fwd_addr = r_slot;
        fwd_data = IDX_NONE;
        if (i_cmd.link1) begin
            fwd_we   = 1'b1;
            fwd_data = i_cmd.front ? r_head : IDX_NONE;
        end else if (i_cmd.link2 && !i_cmd.front && r_tail != IDX_NONE) begin
            fwd_we   = 1'b1;
            fwd_addr = r_tail[AW-1:0];
            fwd_data = slot_ext;
        end else if (i_cmd.unlink && r_bwd_q != IDX_NONE) begin
            fwd_we   = 1'b1;
            fwd_addr = r_bwd_q[AW-1:0];
            fwd_data = r_fwd_q;
        end
    end

    always_comb begin
        bwd_we   = 1'b0;
        bwd_addr = r_slot;
        bwd_data = IDX_NONE;
        if (i_cmd.link1) begin
            bwd_we   = 1'b1;
            bwd_data = i_cmd.front ? IDX_NONE : r_tail;
        end else if (i_cmd.link2 && i_cmd.front && r_head != IDX_NONE) begin
            bwd_we   = 1'b1;
            bwd_addr = r_head[AW-1:0];
            bwd_data = slot_ext;
        end else if (i_cmd.unlink && r_fwd_q != IDX_NONE) begin
            bwd_we   = 1'b1;
            bwd_addr = r_fwd_q[AW-1:0];
            bwd_data = r_bwd_q;
        end
    end

    // store ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.link1) begin
            r_val_mem[r_slot] <= r_value;
        end
        if (fwd_we) begin
            r_fwd_mem[fwd_addr] <= fwd_data;
        end
        if (bwd_we) begin
            r_bwd_mem[bwd_addr] <= bwd_data;
        end
        if (rd_en) begin
            r_val_q <= r_val_mem[rd_addr];
            r_fwd_q <= r_fwd_mem[rd_addr];
            r_bwd_q <= r_bwd_mem[rd_addr];
        end
    end

    // recycled slot stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.unlink) begin
            r_stk_mem[r_sp[AW-1:0]] <= r_cur[AW-1:0];
        end
        if (r_sp != '0) begin
            r_stk_q <= r_stk_mem[stk_rd];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_item.value;
        end
        if (i_cmd.alloc) begin
            // untouched slots first, then recycled ones
            r_slot <= fresh ? r_fill[AW-1:0] : r_stk_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= IDX_NONE;
            r_tail  <= IDX_NONE;
            r_count <= '0;
            r_fill  <= '0;
            r_sp    <= '0;
            r_cur   <= IDX_NONE;
            r_steps <= '0;
        end else begin
            if (i_cmd.load) begin
                r_cur   <= r_head;
                r_steps <= '0;
            end
            if (i_cmd.step) begin
                r_cur   <= r_fwd_q;
                r_steps <= r_steps + 1'b1;
            end
            if (i_cmd.link2) begin
                r_count <= r_count + 1'b1;
                if (fresh) begin
                    r_fill <= r_fill + 1'b1;
                end else begin
                    r_sp <= r_sp - 1'b1;
                end
                if (i_cmd.front) begin
                    r_head <= slot_ext;
                    if (r_head == IDX_NONE) begin
                        r_tail <= slot_ext;
                    end
                end else begin
                    r_tail <= slot_ext;
                    if (r_tail == IDX_NONE) begin
                        r_head <= slot_ext;
                    end
                end
            end
            if (i_cmd.unlink) begin
                r_count <= r_count - 1'b1;
                r_sp    <= r_sp + 1'b1;
                if (r_bwd_q == IDX_NONE) begin
                    r_head <= r_fwd_q;
                end
                if (r_fwd_q == IDX_NONE) begin
                    r_tail <= r_bwd_q;
                end
            end
        end
    end

    assign o_stat.full       = (r_count >= IDX_NONE);
    assign o_stat.cur_none   = (r_cur == IDX_NONE);
    assign o_stat.step_limit = (r_steps >= IDX_NONE);
    assign o_stat.match      = (r_val_q == r_value);
    assign o_stat.count      = 5'(r_count);

endmodule
`default_nettype wire

// ===== hw/rtl/oldr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oldr_ctrl
// Command sequencer: allocate and link for inserts, walk and unlink for
// removes, then one result beat.
// ----------------------------------------------------------------------------
module oldr_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic [1:0]         i_command,
    input  wire oldr_pkg::t_dp_stat i_stat,
    output oldr_pkg::t_dp_cmd       o_cmd,
    output logic                    busy,
    output logic                    o_valid,
    output logic [1:0]              o_status
);
    import oldr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_LINK1,
        S_LINK2,
        S_WALK,
        S_UNLINK,
        S_RESP
    } t_state;

    t_state     r_state;
    logic       r_valid;
    logic [1:0] r_status;
    logic       r_front;
    logic       walk_end;

    assign walk_end = i_stat.cur_none | i_stat.step_limit;

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) & start;
        o_cmd.front  = r_front;
        o_cmd.alloc  = (r_state == S_ALLOC);
        o_cmd.link1  = (r_state == S_LINK1);
        o_cmd.link2  = (r_state == S_LINK2);
        o_cmd.step   = (r_state == S_WALK) & !walk_end & !i_stat.match;
        o_cmd.unlink = (r_state == S_UNLINK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_status <= ST_DONE;
            r_front  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_front <= (i_command == CMD_FRONT);
                        case (i_command)
                            CMD_FRONT, CMD_BACK: begin
                                if (i_stat.full) begin
                                    r_valid  <= 1'b1;
                                    r_status <= ST_FULL;
                                    r_state  <= S_RESP;
                                end else begin
                                    r_state <= S_ALLOC;
                                end
                            end
                            CMD_REMOVE: begin
                                r_state <= S_WALK;
                            end
                            default: begin
                                r_valid  <= 1'b1;
                                r_status <= ST_MISS;
                                r_state  <= S_RESP;
                            end
                        endcase
                    end
                end
                S_ALLOC: begin
                    r_state <= S_LINK1;
                end
                S_LINK1: begin
                    r_state <= S_LINK2;
                end
                S_LINK2: begin
                    r_valid  <= 1'b1;
                    r_status <= ST_DONE;
                    r_state  <= S_RESP;
                end
                S_WALK: begin
                    // end of list checked before the compare
                    if (walk_end) begin
                        r_valid  <= 1'b1;
                        r_status <= ST_MISS;
                        r_state  <= S_RESP;
                    end else if (i_stat.match) begin
                        r_state <= S_UNLINK;
                    end
                end
                S_UNLINK: begin
                    r_valid  <= 1'b1;
                    r_status <= ST_DONE;
                    r_state  <= S_RESP;
                end
                S_RESP: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_status = r_status;

endmodule
`default_nettype wire

// ===== hw/rtl/ordered_list_deque_remove_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// sequence: an insert or append passes the allocate, first link and second link states before its result beat,
//   a refused insert or an unknown command gives it the cycle after the command beat, a remove
//   gives it after walking up to the matching entry and unlinking it (a miss: after the whole list)
// throughput: busy stays high until the result beat is done, so a new command is taken only
//   once the previous one is finished; the list walk reads one link a cycle
// reset: synchronous active-low, list empty, no clearing pass; result beat cannot be held off
// ----------------------------------------------------------------------------
// ordered_list_deque_remove_top
// Bounded doubly linked list of signed values with front insert, back append
// and remove of the first matching entry.
// ----------------------------------------------------------------------------
module ordered_list_deque_remove_top #(
    parameter int CAPACITY = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire oldr_pkg::t_item   i_item,
    output logic                   busy,
    output logic                   o_valid,
    output oldr_pkg::t_result      o_result
);
    import oldr_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_stat   dp_stat;
    logic [1:0] status;

    oldr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_item.command),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd),
        .busy      (busy),
        .o_valid   (o_valid),
        .o_status  (status)
    );

    oldr_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat)
    );

    assign o_result.status        = status;
    assign o_result.element_count = dp_stat.count;

endmodule
`default_nettype wire

// ===== verif/tb_ordered_list_deque_remove_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_deque_remove_top
// Self-checking bench for the bounded ordered list. Front inserts, back
// appends and match-removes are mirrored in a linked-list predictor, and each
// result beat is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_ordered_list_deque_remove_top;
    import oldr_pkg::*;

    localparam int                 LIST_CAP     = 16;
    localparam logic [4:0]         LINK_NONE    = 5'd16;
    localparam logic [1:0]         CMD_UNUSED   = 2'd3;
    localparam int                 RANDOM_CMDS  = 1850;
    localparam int                 CYCLE_LIMIT  = 400000;
    localparam int                 DRAIN_CYCLES = 24;
    localparam int                 MAX_SHOWN    = 10;
    localparam logic signed [31:0] VAL_MIN      = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX      = 32'sh7FFF_FFFF;

    class list_scoreboard;
        logic signed [31:0]  slot_val [LIST_CAP];
        logic [4:0]          fwd_link [LIST_CAP];
        logic [4:0]          bwd_link [LIST_CAP];
        logic [4:0]          head;
        logic [4:0]          tail;
        logic [4:0]          count;
        logic [LIST_CAP-1:0] slot_free;
        t_result             pending_results [$];
        int errors;
        int n_front, n_back, n_remove, n_unused;
        int n_done, n_full, n_miss, n_results;

        function new();
            head      = LINK_NONE;
            tail      = LINK_NONE;
            count     = '0;
            slot_free = '1;
        endfunction

        // lowest free slot is taken
        function logic [1:0] add_entry(logic signed [31:0] v, bit at_front);
            int s;
            s = -1;
            if (count >= LIST_CAP)
                return ST_FULL;
            for (int i = LIST_CAP - 1; i >= 0; i--)
                if (slot_free[i])
                    s = i;
            if (s < 0)
                return ST_FULL;
            slot_free[s] = 1'b0;
            slot_val[s]  = v;
            if (at_front) begin
                bwd_link[s] = LINK_NONE;
                fwd_link[s] = head;
                if (head != LINK_NONE)
                    bwd_link[head] = 5'(s);
                else
                    tail = 5'(s);
                head = 5'(s);
            end else begin
                fwd_link[s] = LINK_NONE;
                bwd_link[s] = tail;
                if (tail != LINK_NONE)
                    fwd_link[tail] = 5'(s);
                else
                    head = 5'(s);
                tail = 5'(s);
            end
            count++;
            return ST_DONE;
        endfunction

        function logic [1:0] drop_first_match(logic signed [31:0] v);
            logic [4:0] cur;
            logic [4:0] nxt;
            logic [4:0] prv;
            int         steps;
            bit         found;
            cur   = head;
            steps = 0;
            found = 1'b0;
            while (!found && cur != LINK_NONE && steps < LIST_CAP) begin
                if (slot_val[cur] == v) begin
                    found = 1'b1;
                end else begin
                    cur = fwd_link[cur];
                    steps++;
                end
            end
            if (!found)
                return ST_MISS;
            nxt = fwd_link[cur];
            prv = bwd_link[cur];
            if (prv != LINK_NONE)
                fwd_link[prv] = nxt;
            else
                head = nxt;
            if (nxt != LINK_NONE)
                bwd_link[nxt] = prv;
            else
                tail = prv;
            slot_free[cur] = 1'b1;
            if (count > 0)
                count--;
            return ST_DONE;
        endfunction

        function void note_command(t_item beat);
            t_result exp;
            case (beat.command)
                CMD_FRONT: begin
                    exp.status = add_entry(beat.value, 1'b1);
                    n_front++;
                end
                CMD_BACK: begin
                    exp.status = add_entry(beat.value, 1'b0);
                    n_back++;
                end
                CMD_REMOVE: begin
                    exp.status = drop_first_match(beat.value);
                    n_remove++;
                end
                default: begin
                    exp.status = ST_MISS;
                    n_unused++;
                end
            endcase
            exp.element_count = count;
            case (exp.status)
                ST_DONE: n_done++;
                ST_FULL: n_full++;
                default: n_miss++;
            endcase
            pending_results.push_back(exp);
        endfunction

        function void check_result(t_result got);
            t_result exp;
            n_results++;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("result beat with no command outstanding: status %0d count %0d",
                             got.status, got.element_count);
                return;
            end
            exp = pending_results.pop_front();
            if (got.status !== exp.status || got.element_count !== exp.element_count) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("mismatch at result %0d: status exp %0d got %0d, count exp %0d got %0d",
                             n_results, exp.status, got.status,
                             exp.element_count, got.element_count);
            end
        endfunction
    endclass

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    t_item       i_item  = '0;
    logic        busy;
    logic        o_valid;
    t_result     o_result;

    list_scoreboard     sb;
    bit                 gaps_on = 1'b1;
    logic signed [31:0] value_pool [8];
    int unsigned        cycle_count = 0;

    ordered_list_deque_remove_top #(
        .CAPACITY (LIST_CAP)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // result is checked before a command taken on the same edge is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                sb.check_result(o_result);
            if (start && !busy)
                sb.note_command(i_item);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    // start is only lowered when a gap follows, so back-to-back beats keep it high
    task automatic send_command(input logic [1:0] cmd, input logic signed [31:0] val);
        int    gap;
        t_item beat;
        gap          = gaps_on ? $urandom_range(0, 10) : 0;
        beat.command = cmd;
        beat.value   = val;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= beat;
        do @(posedge i_clk); while (busy);
    endtask

    // removes lean harder on the pool so that most of them hit
    function automatic logic signed [31:0] pick_value(bit for_remove);
        int r;
        r = $urandom_range(0, 99);
        if (r < (for_remove ? 80 : 60))
            return value_pool[$urandom_range(0, 7)];
        if (r < 90) begin
            case ($urandom_range(0, 3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $signed($urandom);
    endfunction

    initial begin
        int phase_left;
        int grow_pct;
        int r;
        sb = new();
        for (int k = 0; k < 8; k++)
            value_pool[k] = $signed($urandom);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_command(CMD_REMOVE, 32'sd7);   // empty list
        send_command(CMD_UNUSED, VAL_MAX);
        send_command(CMD_FRONT, VAL_MIN);
        send_command(CMD_BACK, VAL_MAX);
        send_command(CMD_FRONT, 32'sd0);
        send_command(CMD_BACK, -32'sd1);
        repeat (LIST_CAP - 4) send_command(CMD_BACK, 32'sd5);
        send_command(CMD_FRONT, 32'sd9);    // store full
        send_command(CMD_BACK, 32'sd9);
        send_command(CMD_REMOVE, 32'sd9);   // walks the whole list and misses
        send_command(CMD_REMOVE, 32'sd0);   // head
        send_command(CMD_REMOVE, -32'sd1);  // interior
        send_command(CMD_REMOVE, 32'sd5);   // first of the duplicates
        send_command(CMD_BACK, 32'sd11);    // reuses a freed slot
        send_command(CMD_REMOVE, 32'sd11);  // tail
        send_command(CMD_UNUSED, 32'sd5);

        // phases alternate between filling, draining and a balanced mix
        phase_left = 0;
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(40, 120);
                case ($urandom_range(0, 3))
                    0:       grow_pct = 80;
                    1:       grow_pct = 20;
                    default: grow_pct = 48;
                endcase
                gaps_on = ($urandom_range(0, 3) != 0);
                for (int k = 0; k < 4; k++)
                    value_pool[$urandom_range(0, 7)] = $signed($urandom);
            end
            phase_left--;
            r = $urandom_range(0, 99);
            if (r < 3)
                send_command(CMD_UNUSED, pick_value(1'b0));
            else if (r < 3 + grow_pct)
                send_command($urandom_range(0, 1) ? CMD_FRONT : CMD_BACK, pick_value(1'b0));
            else
                send_command(CMD_REMOVE, pick_value(1'b1));
        end
        start <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("commands: %0d front insert, %0d back append, %0d remove, %0d unused code",
                 sb.n_front, sb.n_back, sb.n_remove, sb.n_unused);
        $display("outcomes: %0d done, %0d refused full, %0d miss; %0d beats checked, %0d errors",
                 sb.n_done, sb.n_full, sb.n_miss, sb.n_results, sb.errors);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/oldr_pkg.sv
hw/rtl/oldr_dpath.sv
hw/rtl/oldr_ctrl.sv
hw/rtl/ordered_list_deque_remove_top.sv
verif/tb_ordered_list_deque_remove_top.sv
